// ----- sv/csrmv_pkg.sv -----
// Package for the CSR sparse matrix-vector block.
// Holds the item and result structs, operation codes and stage control type.
// No dependencies; every other file refers to it by scoped names.
package csrmv_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int ACC_W = 64;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_NONZERO = 2'd1;
    localparam logic [1:0] OP_EMPTY   = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    row_end;
    } item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] row_result;
        logic [IDX_W-1:0]        row_number;
        logic                    saturated;
    } result_t;

    // Control that travels with a matrix item down the pipeline.
    typedef struct packed {
        logic valid;
        logic nonzero;
        logic closes_row;
    } stage_ctrl_t;

endpackage

// ----- sv/csrmv_fetch.sv -----
// Input register stage of the CSR sparse matrix-vector block.
// Holds the vector store memory: loads write it, nonzeros read their x element.
// Depends on csrmv_pkg.
module csrmv_fetch #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  csrmv_pkg::item_t                 item,
    input  logic                             down_stall,
    output csrmv_pkg::stage_ctrl_t           ctrl,
    output logic signed [csrmv_pkg::VAL_W-1:0] mat_value,
    output logic signed [csrmv_pkg::VAL_W-1:0] vec_value
);

    localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int EXT_W  = ((ADDR_W > csrmv_pkg::IDX_W) ? ADDR_W : csrmv_pkg::IDX_W) + 1;

    logic signed [csrmv_pkg::VAL_W-1:0] mem [VECTOR_DEPTH];

    csrmv_pkg::stage_ctrl_t             ctrl_reg;
    csrmv_pkg::stage_ctrl_t             ctrl_next;
    logic signed [csrmv_pkg::VAL_W-1:0] value_reg;
    logic signed [csrmv_pkg::VAL_W-1:0] x_reg;
    logic                               in_range_reg;

    logic                               accept;
    logic [EXT_W-1:0]                   index_ext;
    logic [ADDR_W-1:0]                  addr;
    logic                               in_range;
    logic                               is_nonzero;
    logic                               is_empty;

    assign item_stall = ctrl_reg.valid && down_stall;
    assign accept     = item_valid && !item_stall;

    assign index_ext  = EXT_W'(item.index);
    assign addr       = index_ext[ADDR_W-1:0];
    assign in_range   = index_ext < EXT_W'(VECTOR_DEPTH);
    assign is_nonzero = item.operation == csrmv_pkg::OP_NONZERO;
    assign is_empty   = item.operation == csrmv_pkg::OP_EMPTY;

    // Loads and unused codes finish here; only row work moves on.
    always_comb
    begin
        ctrl_next = ctrl_reg;
        if (accept)
        begin
            ctrl_next.valid      = is_nonzero || is_empty;
            ctrl_next.nonzero    = is_nonzero;
            ctrl_next.closes_row = is_empty || (is_nonzero && item.row_end);
        end
        else if (!down_stall)
        begin
            ctrl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg    <= item.value;
            in_range_reg <= in_range;
            x_reg        <= mem[addr];
            if (item.operation == csrmv_pkg::OP_LOAD && in_range)
            begin
                mem[addr] <= item.value;
            end
        end
    end

    assign ctrl      = ctrl_reg;
    assign mat_value = value_reg;
    assign vec_value = in_range_reg ? x_reg : '0;

endmodule

// ----- sv/csrmv_mult.sv -----
// Multiply stage of the CSR sparse matrix-vector block.
// Forms the exact Q32.32 product of a Q16.16 nonzero and its x element.
// Depends on csrmv_pkg.
module csrmv_mult (
    input  logic                               clk,
    input  logic                               rst_n,
    input  csrmv_pkg::stage_ctrl_t             up_ctrl,
    input  logic signed [csrmv_pkg::VAL_W-1:0] mat_value,
    input  logic signed [csrmv_pkg::VAL_W-1:0] vec_value,
    output logic                               up_stall,
    input  logic                               down_stall,
    output csrmv_pkg::stage_ctrl_t             ctrl,
    output logic signed [csrmv_pkg::ACC_W-1:0] product
);

    csrmv_pkg::stage_ctrl_t             ctrl_reg;
    logic signed [csrmv_pkg::ACC_W-1:0] product_reg;
    logic signed [csrmv_pkg::ACC_W-1:0] product_next;

    assign up_stall     = ctrl_reg.valid && down_stall;
    assign product_next = csrmv_pkg::ACC_W'(mat_value) * csrmv_pkg::ACC_W'(vec_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (!up_stall)
        begin
            ctrl_reg <= up_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall)
        begin
            product_reg <= product_next;
        end
    end

    assign ctrl    = ctrl_reg;
    assign product = product_reg;

endmodule

// ----- sv/csrmv_accum.sv -----
// Accumulate stage of the CSR sparse matrix-vector block.
// Saturating Q32.32 row accumulator, row counter and the result register.
// Depends on csrmv_pkg.
module csrmv_accum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  csrmv_pkg::stage_ctrl_t             up_ctrl,
    input  logic signed [csrmv_pkg::ACC_W-1:0] product,
    output logic                               up_stall,
    output logic                               result_valid,
    input  logic                               result_stall,
    output csrmv_pkg::result_t                 result
);

    localparam logic [csrmv_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(csrmv_pkg::ACC_W-1){1'b1}}};
    localparam logic [csrmv_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(csrmv_pkg::ACC_W-1){1'b0}}};

    logic signed [csrmv_pkg::ACC_W-1:0] acc_reg;
    logic                               sat_reg;
    logic [csrmv_pkg::IDX_W-1:0]        row_reg;
    logic                               result_valid_reg;
    logic                               result_valid_next;
    csrmv_pkg::result_t                 result_reg;

    logic                               fire;
    logic signed [csrmv_pkg::ACC_W-1:0] addend;
    logic signed [csrmv_pkg::ACC_W-1:0] sum;
    logic                               overflow;
    logic signed [csrmv_pkg::ACC_W-1:0] acc_new;
    logic                               sat_new;

    // Only a row-closing item needs the result register to be free.
    assign up_stall = up_ctrl.valid && up_ctrl.closes_row && result_valid_reg && result_stall;
    assign fire     = up_ctrl.valid && !up_stall;

    assign addend   = up_ctrl.nonzero ? product : '0;
    assign sum      = acc_reg + addend;
    assign overflow = (acc_reg[csrmv_pkg::ACC_W-1] == addend[csrmv_pkg::ACC_W-1]) &&
                      (sum[csrmv_pkg::ACC_W-1] != acc_reg[csrmv_pkg::ACC_W-1]);
    assign acc_new  = overflow ? (acc_reg[csrmv_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
    assign sat_new  = sat_reg || overflow;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (fire && up_ctrl.closes_row)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            sat_reg          <= 1'b0;
            row_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (fire)
            begin
                if (up_ctrl.closes_row)
                begin
                    acc_reg <= '0;
                    sat_reg <= 1'b0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    acc_reg <= acc_new;
                    sat_reg <= sat_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && up_ctrl.closes_row)
        begin
            result_reg.row_result <= acc_new;
            result_reg.row_number <= row_reg;
            result_reg.saturated  <= sat_new;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/csr_sparse_matvec_top.sv -----
// Top level of the CSR sparse matrix-vector block, y = A*x.
// Instantiates csrmv_fetch, csrmv_mult and csrmv_accum; depends on csrmv_pkg.
//
// Usage: first load x through the item channel with load items (index and
// Q16.16 value). Then send the matrix nonzeros in row order as nonzero items
// (column index and Q16.16 value), with row_end set on the last of each row;
// an empty-row item closes a row that has no nonzeros. For every closed row
// one result item appears on the result channel: the Q32.32 saturating sum,
// the row number and a flag that is set if the sum clamped.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// A row result passes the input register, the product register and the result
// register in turn after the item closing the row is accepted; stalls can hold it.
// Throughput: one item per cycle while no stall holds the pipeline;
// the vector store is read and written through one port at input time.
// Reset clears the accumulator, row counter and saturation flag and empties
// the pipeline; the vector store keeps no reset value and must be loaded.
// When the receiver stalls, the result register holds, and items keep
// flowing until a row-closing item reaches it; then the stall backs up
// stage by stage to the item channel.
module csr_sparse_matvec_top #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  csrmv_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output csrmv_pkg::result_t  result
);

    csrmv_pkg::stage_ctrl_t             fetch_ctrl;
    csrmv_pkg::stage_ctrl_t             mult_ctrl;
    logic signed [csrmv_pkg::VAL_W-1:0] mat_value;
    logic signed [csrmv_pkg::VAL_W-1:0] vec_value;
    logic signed [csrmv_pkg::ACC_W-1:0] product;
    logic                               mult_stall;
    logic                               accum_stall;

    csrmv_fetch #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .down_stall (mult_stall),
        .ctrl       (fetch_ctrl),
        .mat_value  (mat_value),
        .vec_value  (vec_value)
    );

    csrmv_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_ctrl    (fetch_ctrl),
        .mat_value  (mat_value),
        .vec_value  (vec_value),
        .up_stall   (mult_stall),
        .down_stall (accum_stall),
        .ctrl       (mult_ctrl),
        .product    (product)
    );

    csrmv_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_ctrl      (mult_ctrl),
        .product      (product),
        .up_stall     (accum_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- verif/tb_csr_sparse_matvec_top.sv -----
// Testbench for csr_sparse_matvec_top: drives load, nonzero and empty-row items
// and checks every row result against a scoreboard that predicts the block.
// Depends on csrmv_pkg and the block's RTL.
module tb_csr_sparse_matvec_top;

    localparam int VECTOR_DEPTH = 1024;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 30;

    // Predicts row results from the item stream and checks the block's output.
    class matvec_scoreboard;
        logic signed [csrmv_pkg::VAL_W-1:0] x_store [VECTOR_DEPTH];
        bit                                 x_loaded [VECTOR_DEPTH];
        logic signed [csrmv_pkg::ACC_W-1:0] row_sum;
        logic [csrmv_pkg::IDX_W-1:0]        row_count;
        bit                                 row_clamped;
        csrmv_pkg::result_t                 expected_rows [$];
        int                                 errors;
        int                                 rows_checked;
        int                                 clamped_rows;

        function void clear();
            row_sum = '0;
            row_count = '0;
            row_clamped = 1'b0;
            errors = 0;
            rows_checked = 0;
            clamped_rows = 0;
            foreach (x_loaded[i])
            begin
                x_loaded[i] = 1'b0;
                x_store[i] = '0;
            end
        endfunction

        function void close_row();
            csrmv_pkg::result_t row;
            row.row_result = row_sum;
            row.row_number = row_count;
            row.saturated = row_clamped;
            expected_rows.push_back(row);
            if (row_clamped)
                clamped_rows++;
            row_sum = '0;
            row_clamped = 1'b0;
            row_count = row_count + 1'b1;
        endfunction

        function void note_item(csrmv_pkg::item_t it);
            logic signed [63:0] a64;
            logic signed [63:0] b64;
            logic signed [63:0] prod;
            logic signed [64:0] wide;
            case (it.operation)
                csrmv_pkg::OP_LOAD:
                begin
                    x_store[it.index] = it.value;
                    x_loaded[it.index] = 1'b1;
                end
                csrmv_pkg::OP_NONZERO:
                begin
                    a64 = $signed(it.value);
                    b64 = $signed(x_store[it.index]);
                    prod = a64 * b64;
                    wide = row_sum;
                    wide = wide + prod;
                    // The two top bits differ only when the 64-bit sum overflowed.
                    if (wide[64] != wide[63])
                    begin
                        row_clamped = 1'b1;
                        row_sum = wide[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
                    end
                    else
                        row_sum = wide[63:0];
                    if (it.row_end)
                        close_row();
                end
                csrmv_pkg::OP_EMPTY:
                    close_row();
                default:
                    ;
            endcase
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        endfunction

        function void check_row(csrmv_pkg::result_t got);
            csrmv_pkg::result_t want;
            if (expected_rows.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected row result, expected none, got %h row %0d",
                             $time, got.row_result, got.row_number);
                return;
            end
            want = expected_rows.pop_front();
            rows_checked++;
            if (got.row_result !== want.row_result)
                report("row_result", want.row_result, got.row_result);
            if (got.row_number !== want.row_number)
                report("row_number", 64'(want.row_number), 64'(got.row_number));
            if (got.saturated !== want.saturated)
                report("saturated", 64'(want.saturated), 64'(got.saturated));
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    csrmv_pkg::item_t   item;
    logic               result_valid;
    logic               result_stall = 1'b0;
    csrmv_pkg::result_t result;

    matvec_scoreboard sb;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_on = 1'b0;
    int  cycles = 0;
    int  item_count = 0;
    event hold_go;

    csr_sparse_matvec_top #(.VECTOR_DEPTH(VECTOR_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
        result_stall <= hold_on || ($urandom_range(99) < stall_pct);

    // Long receiver hold-off, counted here so the sender keeps offering items.
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_row(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rows still expected", cycles, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic csrmv_pkg::item_t make_item(logic [1:0] op, int unsigned idx,
                                                   logic [31:0] val, bit last);
        csrmv_pkg::item_t it;
        it.operation = op;
        it.index = idx[csrmv_pkg::IDX_W-1:0];
        it.value = val;
        it.row_end = last;
        return it;
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        int t;
        case ($urandom_range(7))
            0, 1:    return $urandom();
            2:       return extreme_value();
            default:
            begin
                t = int'($urandom_range(2097152)) - 1048576;
                return t;
            end
        endcase
    endfunction

    // Only columns whose vector element has been loaded are ever read.
    function automatic int unsigned pick_column();
        int unsigned c;
        do
            c = $urandom_range(VECTOR_DEPTH - 1);
        while (!sb.x_loaded[c]);
        return c;
    endfunction

    task automatic send_item(csrmv_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(it);
        if (it.operation != OP_UNUSED)
            item_count++;
    endtask

    task automatic send_row();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            send_item(make_item(csrmv_pkg::OP_NONZERO, pick_column(), rand_value(),
                                i == n - 1));
    endtask

    task automatic run_random(int target);
        int start;
        int r;
        int k;
        start = item_count;
        while (item_count - start < target)
        begin
            r = $urandom_range(99);
            if (r < 70)
                send_row();
            else if (r < 80)
                send_item(make_item(csrmv_pkg::OP_EMPTY, $urandom_range(1023), $urandom(),
                                    1'($urandom_range(1))));
            else if (r < 92)
            begin
                k = $urandom_range(1, 3);
                repeat (k)
                    send_item(make_item(csrmv_pkg::OP_LOAD, $urandom_range(VECTOR_DEPTH - 1),
                                        rand_value(), 1'($urandom_range(1))));
            end
            else if (r < 96)
                send_item(make_item(OP_UNUSED, $urandom_range(1023), $urandom(),
                                    1'($urandom_range(1))));
            else
            begin
                // A row left open by nonzeros and then closed by an empty-row item.
                k = $urandom_range(1, 3);
                repeat (k)
                    send_item(make_item(csrmv_pkg::OP_NONZERO, pick_column(), rand_value(),
                                        1'b0));
                send_item(make_item(csrmv_pkg::OP_EMPTY, 0, 0, 1'b0));
            end
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: field extremes, saturation both ways, open rows closed
        // by an empty-row item, and ignored codes and markers.
        send_item(make_item(csrmv_pkg::OP_LOAD, 0, 32'h7FFF_FFFF, 1'b1));
        send_item(make_item(csrmv_pkg::OP_LOAD, 1023, 32'h8000_0000, 1'b0));
        send_item(make_item(csrmv_pkg::OP_LOAD, 512, 32'h0000_0000, 1'b0));
        send_item(make_item(csrmv_pkg::OP_LOAD, 1, 32'h0001_0000, 1'b0));
        send_item(make_item(OP_UNUSED, 1023, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 1, 32'h0001_0000, 1'b1));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 1023, 32'h8000_0000, 1'b0));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 1023, 32'h8000_0000, 1'b0));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 0, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 1, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 0, 32'h8000_0000, 1'b0));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 0, 32'h8000_0000, 1'b0));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 0, 32'h8000_0000, 1'b1));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 512, 32'h7FFF_FFFF, 1'b1));
        send_item(make_item(csrmv_pkg::OP_EMPTY, 1023, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 1, 32'h0000_0005, 1'b0));
        send_item(make_item(csrmv_pkg::OP_EMPTY, 0, 0, 1'b0));
        send_item(make_item(csrmv_pkg::OP_NONZERO, 0, 32'h0000_0000, 1'b1));

        repeat (60)
            send_item(make_item(csrmv_pkg::OP_LOAD, $urandom_range(VECTOR_DEPTH - 1),
                                rand_value(), 1'($urandom_range(1))));

        send_idle_pct <= 0;
        stall_pct <= 0;
        run_random(180);
        send_idle_pct <= 83;
        stall_pct <= 0;
        run_random(180);
        send_idle_pct <= 0;
        stall_pct <= 83;
        run_random(180);
        send_idle_pct <= 6;
        stall_pct <= 6;
        run_random(180);

        // Receiver holds off while rows keep coming, so the stall backs up.
        send_idle_pct <= 0;
        stall_pct <= 0;
        -> hold_go;
        repeat (20)
            send_row();

        send_idle_pct <= 6;
        stall_pct <= 6;
        repeat (10)
            send_row();
        item_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Sent %0d items and checked %0d row results, %0d of them saturated,",
                 item_count, sb.rows_checked, sb.clamped_rows);
        $display("under four idling mixes and one long receiver hold-off that filled the block.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
